// ===== rtl/core/rbsm_pkg.sv =====
// Package for the ring buffer slot manager: sizes, codes and payload types.
package rbsm_pkg;

  // Ring size and derived widths
  localparam int BUF_SIZE = 8;
  localparam int SLOT_AW  = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
  localparam int CNT_W    = $clog2(BUF_SIZE + 1);
  localparam int ELEM_W   = 9;
  localparam int SUM_W    = ELEM_W + 1;

  // Request opcodes
  localparam logic [2:0] OP_ACQUIRE    = 3'd0;
  localparam logic [2:0] OP_TAKE       = 3'd1;
  localparam logic [2:0] OP_MARK_FREE  = 3'd2;
  localparam logic [2:0] OP_MARK_READ  = 3'd3;
  localparam logic [2:0] OP_MARK_WRITE = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  // Slot status codes
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] slot_index;
  } rbsm_in_t;

  typedef struct packed {
    logic       granted;
    logic [7:0] slot_number;
    logic [1:0] slot_state;
    logic       is_full;
    logic       is_empty;
  } rbsm_out_t;

  // Advance a ring pointer with wrap after the last slot
  function automatic logic [SLOT_AW-1:0] next_slot(input logic [SLOT_AW-1:0] p);
    logic [SLOT_AW-1:0] res;
    if (p == SLOT_AW'(BUF_SIZE - 1)) begin
      res = '0;
    end else begin
      res = p + SLOT_AW'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/rbsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbsm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/ring_buffer_slot_manager_unit.sv =====
// Top level of the ring buffer slot manager: sequencer, status RAM and result register.
//
// One request at a time. After a request is accepted the sequencer walks the
// status RAM one slot per cycle to count busy slots, then reads the addressed
// slot, updates it and loads the result register. A single shared add and
// compare unit gives the full test to decode and to the result load. The scan
// allows for the registered RAM read and sets the pace. Decode, slot update
// and result load each have their own state, and the result is loaded when
// the output register is free. The next request can be accepted in the cycle
// after the result is loaded. in_stall is high from acceptance until the
// result is loaded; the result register lets the next request be accepted
// while a result still waits.
// Slot status comes out of reset as all free through per-slot valid bits, so
// there is no clearing pass after reset.
module ring_buffer_slot_manager_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rbsm_pkg::rbsm_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rbsm_pkg::rbsm_out_t out_data
);
  import rbsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DEC  = 5'b00100,
    S_RD   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [7:0]          idx_r, idx_nxt;
  logic [ELEM_W-1:0]   count_r, count_nxt;
  logic [SLOT_AW-1:0]  front_r, front_nxt;
  logic [SLOT_AW-1:0]  rear_r, rear_nxt;
  logic [CNT_W-1:0]    busy_r, busy_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic                has_tgt_r, has_tgt_nxt;
  logic [SLOT_AW-1:0]  tgt_r, tgt_nxt;
  logic [SLOT_AW-1:0]  raddr_q_r, raddr_q_nxt;
  logic [BUF_SIZE-1:0] vld_r, vld_nxt;
  logic                res_grant_r, res_grant_nxt;
  logic [7:0]          res_num_r, res_num_nxt;
  logic [1:0]          res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  rbsm_out_t           out_data_r, out_data_nxt;

  logic                in_acc;
  logic                out_free;
  logic [SUM_W-1:0]    occ_sum;
  logic                full_now;
  logic                idx_ok;
  logic                scan_done;
  logic [SLOT_AW-1:0]  rd_addr;
  logic [1:0]          ram_q;
  logic [1:0]          st_old;
  logic [1:0]          st_new;
  logic                wr_en;

  // Status RAM
  rbsm_ram #(
    .WIDTH (2),
    .DEPTH (BUF_SIZE)
  ) u_status_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tgt_r),
    .wr_data (st_new),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared occupancy add and compare
  assign occ_sum  = SUM_W'(count_r) + SUM_W'(busy_r);
  assign full_now = (occ_sum >= SUM_W'(BUF_SIZE));

  assign idx_ok    = ({1'b0, idx_r} < 9'(BUF_SIZE));
  assign scan_done = (scan_r == CNT_W'(BUF_SIZE));

  // Read data as seen through the valid bits: never-written slots are free
  assign st_old = vld_r[raddr_q_r] ? ram_q : ST_FREE;

  // Choose the RAM read address
  always_comb begin
    rd_addr = scan_r[SLOT_AW-1:0];
    if (state_r == S_DEC) begin
      rd_addr = tgt_nxt;
    end
  end

  // Work out the new status of the addressed slot
  always_comb begin
    st_new = st_old;
    if (op_r == OP_ACQUIRE) begin
      if (st_old == ST_FREE) begin
        st_new = ST_WRITE;
      end
    end else if (op_r == OP_TAKE) begin
      if (st_old == ST_FREE) begin
        st_new = ST_READ;
      end
    end else if (op_r == OP_MARK_FREE) begin
      st_new = ST_FREE;
    end else if (op_r == OP_MARK_READ) begin
      st_new = ST_READ;
    end else if (op_r == OP_MARK_WRITE) begin
      st_new = ST_WRITE;
    end
  end

  assign wr_en = (state_r == S_RD) && has_tgt_r;

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    busy_nxt      = busy_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    has_tgt_nxt   = has_tgt_r;
    tgt_nxt       = tgt_r;
    raddr_q_nxt   = rd_addr;
    vld_nxt       = vld_r;
    res_grant_nxt = res_grant_r;
    res_num_nxt   = res_num_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Latch the request and start the scan
        if (in_acc) begin
          op_nxt    = in_data.opcode;
          idx_nxt   = in_data.slot_index;
          busy_nxt  = '0;
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Count busy slots one read at a time
        if (pend_r && (st_old != ST_FREE)) begin
          busy_nxt = busy_r + CNT_W'(1);
        end
        if (!scan_done) begin
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        // Pick the target slot and move the count and the front pointer
        has_tgt_nxt = 1'b0;
        tgt_nxt     = '0;
        if (op_r == OP_ACQUIRE) begin
          if (!full_now) begin
            count_nxt   = count_r + ELEM_W'(1);
            front_nxt   = next_slot(front_r);
            has_tgt_nxt = 1'b1;
            tgt_nxt     = next_slot(front_r);
          end
        end else if (op_r == OP_TAKE) begin
          if (count_r != '0) begin
            count_nxt   = count_r - ELEM_W'(1);
            has_tgt_nxt = 1'b1;
            tgt_nxt     = rear_r;
          end
        end else if (idx_ok) begin
          has_tgt_nxt = 1'b1;
          tgt_nxt     = idx_r[SLOT_AW-1:0];
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        // Update the slot, the busy count, the rear pointer and the pending result
        res_grant_nxt = 1'b0;
        res_st_nxt    = ST_FREE;
        if (op_r == OP_ACQUIRE || op_r == OP_TAKE) begin
          res_num_nxt = 8'(tgt_r);
        end else begin
          res_num_nxt = idx_r;
        end
        if (has_tgt_r) begin
          vld_nxt[tgt_r] = 1'b1;
          res_st_nxt     = st_new;
          busy_nxt       = busy_r + CNT_W'(st_new != ST_FREE)
                                  - CNT_W'(st_old != ST_FREE);
          if ((op_r == OP_ACQUIRE || op_r == OP_TAKE) && st_old == ST_FREE) begin
            res_grant_nxt = 1'b1;
          end
          if (op_r == OP_TAKE && st_old == ST_FREE) begin
            rear_nxt = next_slot(tgt_r);
          end
        end else begin
          res_num_nxt = (op_r == OP_ACQUIRE || op_r == OP_TAKE) ? 8'd0 : idx_r;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Load the result when the output register is free
        if (out_free) begin
          out_data_nxt.granted     = res_grant_r;
          out_data_nxt.slot_number = res_num_r;
          out_data_nxt.slot_state  = res_st_r;
          out_data_nxt.is_full     = full_now;
          out_data_nxt.is_empty    = (count_r == '0);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      front_r     <= SLOT_AW'(BUF_SIZE - 1);
      rear_r      <= '0;
      vld_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      vld_r       <= vld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    busy_r      <= busy_nxt;
    scan_r      <= scan_nxt;
    has_tgt_r   <= has_tgt_nxt;
    tgt_r       <= tgt_nxt;
    raddr_q_r   <= raddr_q_nxt;
    res_grant_r <= res_grant_nxt;
    res_num_r   <= res_num_nxt;
    res_st_r    <= res_st_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ring buffer slot manager: random and directed requests.
`timescale 1ns / 100ps

module tb_top;
  import rbsm_pkg::*;

  localparam int RANDOM_REQUESTS = 1130;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Track slot ring state and the replies each accepted request must produce
  class slot_ring_tracker;
    logic [8:0] elem_count;
    logic [7:0] front_ptr;
    logic [7:0] rear_ptr;
    logic [1:0] slot_st [BUF_SIZE];
    rbsm_out_t  replies_due [$];
    int         errors;

    function new();
      elem_count = '0;
      front_ptr  = 8'(BUF_SIZE - 1);
      rear_ptr   = '0;
      foreach (slot_st[i]) begin
        slot_st[i] = ST_FREE;
      end
      errors = 0;
    endfunction

    function int wrap_next(int p);
      return (p + 1 >= BUF_SIZE) ? 0 : p + 1;
    endfunction

    // Full when pending elements plus busy slots cover the whole ring
    function bit ring_full();
      int busy;
      busy = 0;
      foreach (slot_st[i]) begin
        if (slot_st[i] != ST_FREE) busy++;
      end
      return (int'(elem_count) + busy) >= BUF_SIZE;
    endfunction

    // Apply one accepted request and queue the reply it produces
    function void note_request(rbsm_in_t req);
      rbsm_out_t rep;
      int        s;
      int        idx;
      rep = '0;
      idx = int'(req.slot_index);
      case (req.opcode)
        OP_ACQUIRE: begin
          if (!ring_full()) begin
            // count and front advance even when the new slot turns out busy
            elem_count = elem_count + 9'd1;
            front_ptr  = 8'(wrap_next(int'(front_ptr)));
            s = int'(front_ptr);
            if (slot_st[s] == ST_FREE) begin
              slot_st[s]  = ST_WRITE;
              rep.granted = 1'b1;
            end
            rep.slot_number = 8'(s);
            rep.slot_state  = slot_st[s];
          end
        end
        OP_TAKE: begin
          if (elem_count != 0) begin
            // count drops even when the rear slot is busy; rear holds then
            elem_count = elem_count - 9'd1;
            s = (int'(rear_ptr) < BUF_SIZE) ? int'(rear_ptr) : 0;
            if (slot_st[s] == ST_FREE) begin
              slot_st[s]  = ST_READ;
              rear_ptr    = 8'(wrap_next(s));
              rep.granted = 1'b1;
            end
            rep.slot_number = 8'(s);
            rep.slot_state  = slot_st[s];
          end
        end
        default: begin
          // mark, query and unused opcodes; out-of-range slots only echo the index
          rep.slot_number = req.slot_index;
          if (idx < BUF_SIZE) begin
            if (req.opcode == OP_MARK_FREE) begin
              slot_st[idx] = ST_FREE;
            end else if (req.opcode == OP_MARK_READ) begin
              slot_st[idx] = ST_READ;
            end else if (req.opcode == OP_MARK_WRITE) begin
              slot_st[idx] = ST_WRITE;
            end
            rep.slot_state = slot_st[idx];
          end
        end
      endcase
      rep.is_full  = ring_full();
      rep.is_empty = (elem_count == 0);
      replies_due.push_back(rep);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    // Compare one accepted reply against the oldest one due
    function void check_result(rbsm_out_t got);
      rbsm_out_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply with none due, expected nothing got %p", $time, got);
      end else begin
        want = replies_due.pop_front();
        compare_field("granted", want.granted, got.granted);
        compare_field("slot_number", want.slot_number, got.slot_number);
        compare_field("slot_state", want.slot_state, got.slot_state);
        compare_field("is_full", want.is_full, got.is_full);
        compare_field("is_empty", want.is_empty, got.is_empty);
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rbsm_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rbsm_out_t out_data;

  slot_ring_tracker tracker = new();
  bit steady       = 1'b0;
  int replies_seen = 0;
  int cycle_count  = 0;

  ring_buffer_slot_manager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic rbsm_in_t make_req(logic [2:0] op, logic [7:0] idx);
    rbsm_in_t r;
    r.opcode     = op;
    r.slot_index = idx;
    return r;
  endfunction

  // Mostly ring traffic with in-range marks; the rest is noise
  function automatic rbsm_in_t random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return make_req(OP_ACQUIRE, 8'($urandom));
    if (pick < 55) return make_req(OP_TAKE, 8'($urandom));
    if (pick < 75) return make_req(OP_MARK_FREE, 8'($urandom_range(0, BUF_SIZE - 1)));
    if (pick < 83) return make_req(OP_MARK_READ, 8'($urandom_range(0, BUF_SIZE - 1)));
    if (pick < 88) return make_req(OP_MARK_WRITE, 8'($urandom_range(0, BUF_SIZE - 1)));
    if (pick < 93) return make_req(OP_QUERY, 8'($urandom_range(0, BUF_SIZE - 1)));
    return make_req(3'($urandom_range(2, 7)), 8'($urandom));
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(rbsm_in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    tracker.note_request(req);
  endtask

  // Accept replies with random stalls and a long hold-off twice
  initial begin : reply_sink
    int hold;
    int pick;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_result(out_data);
        replies_seen++;
        if (replies_seen == 200 || replies_seen == 800) hold = HOLD_OFF_CYCLES;
      end
      pick = $urandom_range(0, 99);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (steady || pick < 70) begin
        out_stall <= 1'b0;
      end else if (pick < 95) begin
        hold = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        hold = $urandom_range(14, 49);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rbsm_in_t directed [$];
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state, empty take, unused opcodes, busy slots on both pointers
    directed.push_back(make_req(OP_QUERY, 8'd0));
    directed.push_back(make_req(OP_TAKE, 8'd0));
    directed.push_back(make_req(3'd6, 8'd3));
    directed.push_back(make_req(3'd7, 8'hFF));
    directed.push_back(make_req(OP_MARK_WRITE, 8'd1));
    directed.push_back(make_req(OP_ACQUIRE, 8'hFF));
    directed.push_back(make_req(OP_ACQUIRE, 8'd0));
    directed.push_back(make_req(OP_TAKE, 8'hFF));
    directed.push_back(make_req(OP_MARK_FREE, 8'd0));
    directed.push_back(make_req(OP_TAKE, 8'd0));
    // Out-of-range marks and the last slot
    directed.push_back(make_req(OP_MARK_READ, 8'(BUF_SIZE)));
    directed.push_back(make_req(OP_MARK_FREE, 8'h80));
    directed.push_back(make_req(OP_QUERY, 8'(BUF_SIZE - 1)));
    // Fill the ring, then acquire while full
    directed.push_back(make_req(OP_ACQUIRE, 8'd0));
    directed.push_back(make_req(OP_ACQUIRE, 8'd0));
    directed.push_back(make_req(OP_ACQUIRE, 8'd0));
    directed.push_back(make_req(OP_ACQUIRE, 8'd0));
    // Release and re-mark a few slots
    directed.push_back(make_req(OP_MARK_FREE, 8'd0));
    directed.push_back(make_req(OP_MARK_FREE, 8'd1));
    directed.push_back(make_req(OP_MARK_WRITE, 8'(BUF_SIZE - 1)));
    directed.push_back(make_req(OP_QUERY, 8'(BUF_SIZE - 1)));
    foreach (directed[i]) begin
      send_request(directed[i]);
    end

    // Random traffic with one stretch of back-to-back requests
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 300 && n < 420);
      send_request(random_request());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then let stray replies show up
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (BUF_SIZE + 40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
